[hdl/frta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frta_pkg: shared types and constants for the ties-away rounding unit
// Lane format codes, the per-lane stage record and the decode classes.
// ----------------------------------------------------------------------------
package frta_pkg;

  typedef enum logic [0:0] {
    FMT_B32 = 1'b0,
    FMT_B64 = 1'b1
  } fmt_t;

  // How a lane is finished after the add stage.
  typedef enum logic [2:0] {
    CLS_PASS = 3'd0,  // unchanged
    CLS_QNAN = 3'd1,  // quiet the NaN
    CLS_ZERO = 3'd2,  // signed zero
    CLS_ONE  = 3'd3,  // signed one
    CLS_RND  = 3'd4   // add half, clear fraction
  } cls_t;

  // Decoded 64-bit lane slot; in binary32 mode each slot holds two lanes.
  typedef struct packed {
    logic [63:0] word;
    logic [63:0] mask;
    logic [63:0] half;
    cls_t        cls_lo;
    cls_t        cls_hi;
  } slot_t;

endpackage

[hdl/frta_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frta_decode: exponent decode for one 64-bit slot
// Classifies the lanes and builds the half and fraction masks.
// ----------------------------------------------------------------------------
module frta_decode (
  input  frta_pkg::fmt_t fmt,
  input  logic [63:0]    word,
  output frta_pkg::slot_t slot
);
  import frta_pkg::*;

  function automatic cls_t cls32(input logic [31:0] x);
    logic [7:0] e;
    e = x[30:23];
    if (e == 8'hff) cls32 = (x[22:0] != 23'd0) ? CLS_QNAN : CLS_PASS;
    else if (e < 8'd126) cls32 = CLS_ZERO;
    else if (e == 8'd126) cls32 = CLS_ONE;
    else if (e >= 8'd150) cls32 = CLS_PASS;
    else cls32 = CLS_RND;
  endfunction

  function automatic cls_t cls64(input logic [63:0] x);
    logic [10:0] e;
    e = x[62:52];
    if (e == 11'h7ff) cls64 = (x[51:0] != 52'd0) ? CLS_QNAN : CLS_PASS;
    else if (e < 11'd1022) cls64 = CLS_ZERO;
    else if (e == 11'd1022) cls64 = CLS_ONE;
    else if (e >= 11'd1075) cls64 = CLS_PASS;
    else cls64 = CLS_RND;
  endfunction

  logic [4:0]  fb_lo32, fb_hi32;
  logic [5:0]  fb64;
  logic [31:0] m_lo, m_hi;
  logic [63:0] m64;

  always_comb begin
    // Fraction bits = bias + mantissa width - exponent; only used when rounding.
    fb_lo32 = 5'(8'd150 - word[30:23]);
    fb_hi32 = 5'(8'd150 - word[62:55]);
    fb64    = 6'(11'd1075 - word[62:52]);
    m_lo = ~(32'hffff_ffff << fb_lo32);
    m_hi = ~(32'hffff_ffff << fb_hi32);
    m64  = ~(64'hffff_ffff_ffff_ffff << fb64);
    slot.word = word;
    if (fmt == FMT_B64) begin
      slot.mask   = m64;
      slot.half   = (m64 >> 1) + 64'd1;
      slot.cls_lo = cls64(word);
      slot.cls_hi = CLS_PASS;
    end else begin
      slot.mask   = {m_hi, m_lo};
      slot.half   = {(m_hi >> 1) + 32'd1, (m_lo >> 1) + 32'd1};
      slot.cls_lo = cls32(word[31:0]);
      slot.cls_hi = cls32(word[63:32]);
    end
  end

endmodule

[hdl/frta_finish.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frta_finish: result select for one 64-bit slot
// Applies the lane class to the rounded magnitude.
// ----------------------------------------------------------------------------
module frta_finish (
  input  frta_pkg::fmt_t  fmt,
  input  frta_pkg::slot_t slot,
  input  logic [63:0]     sum,
  output logic [63:0]     result
);
  import frta_pkg::*;

  function automatic logic [31:0] fin32(input cls_t c, input logic [31:0] x,
                                        input logic [31:0] s, input logic [31:0] m);
    case (c)
      CLS_QNAN: fin32 = x | 32'h0040_0000;
      CLS_ZERO: fin32 = {x[31], 31'd0};
      CLS_ONE:  fin32 = {x[31], 31'h3f80_0000};
      CLS_RND:  fin32 = {x[31], s[30:0] & ~m[30:0]};
      default:  fin32 = x;
    endcase
  endfunction

  always_comb begin
    if (fmt == FMT_B64) begin
      case (slot.cls_lo)
        CLS_QNAN: result = slot.word | 64'h0008_0000_0000_0000;
        CLS_ZERO: result = {slot.word[63], 63'd0};
        CLS_ONE:  result = {slot.word[63], 63'h3ff0_0000_0000_0000};
        CLS_RND:  result = {slot.word[63], sum[62:0] & ~slot.mask[62:0]};
        default:  result = slot.word;
      endcase
    end else begin
      result = {fin32(slot.cls_hi, slot.word[63:32], sum[63:32], slot.mask[63:32]),
                fin32(slot.cls_lo, slot.word[31:0], sum[31:0], slot.mask[31:0])};
    end
  end

endmodule

[hdl/float_round_ties_away.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_round_ties_away: round to integral, ties away from zero
// Four binary32 or two binary64 lanes per 128-bit transaction.
// ----------------------------------------------------------------------------
// Pipeline: out_tvalid rises once a transaction has passed the capture, decode
// and add registers; the result select is combinational on the output, so a
// result can be accepted as soon as out_tvalid is high.
// Throughput: one transaction per cycle; the three-stage pipeline advances
// whenever its last stage is empty or being read.
// Reset: rst_n clears the stage valid bits only; payload is not reset.
module float_round_ties_away (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // [63:0] word_lo, [127:64] word_hi
  input  logic          in_tuser,   // cmd: 0 = four binary32, 1 = two binary64
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata   // [63:0] result_lo, [127:64] result_hi
);
  import frta_pkg::*;

  // Stage valid bits; a stage moves when the one after it can take data.
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  fmt_t        fmt1_r, fmt2_r;
  logic [63:0] lo1_r, hi1_r;
  slot_t       slo2_r, shi2_r, slo3_r, shi3_r;
  logic [63:0] slo2_nxt_sum, shi2_nxt_sum, sumlo3_r, sumhi3_r;
  fmt_t        fmt3_r;
  slot_t       dlo, dhi;
  logic [63:0] rlo, rhi;

  assign adv3 = !v3_r || out_tready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_tready  = adv1;
  assign out_tvalid = v3_r;

  // Stage 1: capture input.
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv1) v1_r <= in_tvalid;
    if (adv1 && in_tvalid) begin
      fmt1_r <= fmt_t'(in_tuser);
      lo1_r  <= in_tdata[63:0];
      hi1_r  <= in_tdata[127:64];
    end
  end

  // Stage 2: decode classes and masks.
  frta_decode u_dec_lo (.fmt(fmt1_r), .word(lo1_r), .slot(dlo));
  frta_decode u_dec_hi (.fmt(fmt1_r), .word(hi1_r), .slot(dhi));

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv2) v2_r <= v1_r;
    if (adv2 && v1_r) begin
      fmt2_r <= fmt1_r;
      slo2_r <= dlo;
      shi2_r <= dhi;
    end
  end

  // Stage 3: add half; in binary32 mode the sign bits keep carries between lanes.
  always_comb begin
    slo2_nxt_sum = {1'b0, slo2_r.word[62:0]} + slo2_r.half;
    shi2_nxt_sum = {1'b0, shi2_r.word[62:0]} + shi2_r.half;
    if (fmt2_r == FMT_B32) begin
      slo2_nxt_sum[63:32] = {1'b0, slo2_r.word[62:32]} + slo2_r.half[63:32];
      shi2_nxt_sum[63:32] = {1'b0, shi2_r.word[62:32]} + shi2_r.half[63:32];
      slo2_nxt_sum[31:0]  = {1'b0, slo2_r.word[30:0]} + slo2_r.half[31:0];
      shi2_nxt_sum[31:0]  = {1'b0, shi2_r.word[30:0]} + shi2_r.half[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv3) v3_r <= v2_r;
    if (adv3 && v2_r) begin
      fmt3_r   <= fmt2_r;
      slo3_r   <= slo2_r;
      shi3_r   <= shi2_r;
      sumlo3_r <= slo2_nxt_sum;
      sumhi3_r <= shi2_nxt_sum;
    end
  end

  // The result select works straight from the stage 3 registers and drives
  // out_tdata combinationally, so the data holds while stage 3 is stalled.
  frta_finish u_fin_lo (.fmt(fmt3_r), .slot(slo3_r), .sum(sumlo3_r), .result(rlo));
  frta_finish u_fin_hi (.fmt(fmt3_r), .slot(shi3_r), .sum(sumhi3_r), .result(rhi));

  assign out_tdata = {rhi, rlo};

  // A held result must not change while it waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // Input is always taken when the pipeline is empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r && !v2_r && !v3_r |-> in_tready)
    else $error("empty pipeline refused input");
  // An accepted transaction is held in the first stage register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted transaction lost");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ties-away rounding unit
// Drives 128-bit vectors in binary32 and binary64 lane formats, predicts the
// rounded lanes with a bit-level model and compares every output transaction.
// ----------------------------------------------------------------------------
module testbench;
  import frta_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;

  int unsigned mismatch_count;
  int unsigned vectors_sent;
  int unsigned vectors_checked;
  int unsigned wide_sent;

  float_round_ties_away u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  // Round one binary32 lane to nearest integral, halves away from zero.
  function automatic logic [31:0] round_single(input logic [31:0] x);
    logic [31:0] sign;
    logic [31:0] mag;
    logic [7:0]  expo;
    int          fbits;
    sign = x & 32'h8000_0000;
    mag  = x & 32'h7fff_ffff;
    expo = mag[30:23];
    if (expo == 8'hff)
      return (mag[22:0] != 0) ? (x | 32'h0040_0000) : x;
    if (expo < 8'd126) return sign;
    if (expo == 8'd126) return sign | 32'h3f80_0000;
    if (expo >= 8'd150) return x;
    fbits = 150 - expo;
    mag = (mag + (32'd1 << (fbits - 1))) & ~((32'd1 << fbits) - 32'd1);
    return sign | mag;
  endfunction

  function automatic logic [63:0] round_double(input logic [63:0] x);
    logic [63:0] sign;
    logic [63:0] mag;
    logic [10:0] expo;
    int          fbits;
    sign = x & 64'h8000_0000_0000_0000;
    mag  = x & 64'h7fff_ffff_ffff_ffff;
    expo = mag[62:52];
    if (expo == 11'h7ff)
      return (mag[51:0] != 0) ? (x | 64'h0008_0000_0000_0000) : x;
    if (expo < 11'd1022) return sign;
    if (expo == 11'd1022) return sign | 64'h3ff0_0000_0000_0000;
    if (expo >= 11'd1075) return x;
    fbits = 1075 - expo;
    mag = (mag + (64'd1 << (fbits - 1))) & ~((64'd1 << fbits) - 64'd1);
    return sign | mag;
  endfunction

  function automatic logic [127:0] round_vector(input fmt_t fmt, input logic [127:0] v);
    logic [127:0] r;
    if (fmt == FMT_B64) begin
      r[63:0]   = round_double(v[63:0]);
      r[127:64] = round_double(v[127:64]);
    end else begin
      for (int k = 0; k < 4; k++) r[32*k +: 32] = round_single(v[32*k +: 32]);
    end
    return r;
  endfunction

  // Holds the rounded vectors expected at the output, oldest first.
  class rounding_scoreboard;
    logic [127:0] pending_rounded[$];

    function void note_vector(fmt_t fmt, logic [127:0] v);
      pending_rounded.push_back(round_vector(fmt, v));
    endfunction

    function void check_result(logic [127:0] got);
      logic [127:0] want;
      if (pending_rounded.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_rounded.pop_front();
      if (got[63:0] !== want[63:0])
        report_mismatch($sformatf("result_lo got %h want %h", got[63:0], want[63:0]));
      if (got[127:64] !== want[127:64])
        report_mismatch($sformatf("result_hi got %h want %h", got[127:64], want[127:64]));
    endfunction
  endclass

  rounding_scoreboard board = new();

  // Output monitor: every accepted output transaction is checked.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata);
      vectors_checked++;
    end
  end

  // Accepted input transactions feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      board.note_vector(fmt_t'(in_tuser), in_tdata);
      vectors_sent++;
      if (in_tuser) wide_sent++;
    end
  end

  // Receiver back-pressure: picks at random between free-running, mostly-ready,
  // mostly-stalled and periodic-stall modes so stalls land on every pipeline stage.
  initial begin
    int mode;
    int left;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_tready <= (left % 7 != 0);
        end
      endcase
    end
  end

  // Builds a binary32 lane of an interesting kind with random content.
  function automatic logic [31:0] pick_single();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 5))
      0: r[30:23] = 8'hff;
      1: r[30:23] = 8'($urandom_range(0, 126));
      2: r[30:23] = 8'($urandom_range(127, 151));
      3: r[30:23] = 8'($urandom_range(120, 160));
      4: begin
        r[30:23] = 8'($urandom_range(127, 149));
        // Force an exact half: the bit just below the integer point set.
        r[22:0] = r[22:0] & ~((23'd1 << (150 - r[30:23])) - 23'd1);
        r[22:0] = r[22:0] | (23'd1 << (149 - r[30:23]));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pick_double();
    logic [63:0] r;
    int          e;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: r[62:52] = 11'h7ff;
      1: r[62:52] = 11'($urandom_range(0, 1022));
      2: r[62:52] = 11'($urandom_range(1023, 1076));
      3: r[62:52] = 11'($urandom_range(1000, 1100));
      4: begin
        e = $urandom_range(1023, 1074);
        r[62:52] = 11'(e);
        r[51:0] = r[51:0] & ~((52'd1 << (1075 - e)) - 52'd1);
        r[51:0] = r[51:0] | (52'd1 << (1074 - e));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one vector and holds it until the block accepts it.
  task automatic send_vector(input fmt_t fmt, input logic [127:0] v);
    in_tvalid <= 1'b1;
    in_tuser  <= fmt;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    logic [127:0] v;
    fmt_t         fmt;
    int           burst;
    int           wait_cycles;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    mismatch_count  = 0;
    vectors_sent    = 0;
    vectors_checked = 0;
    wide_sent       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vectors: zeros, infinities, NaNs, halves, tiny and huge values.
    send_vector(FMT_B32, {32'h8000_0000, 32'h0000_0000, 32'hff80_0000, 32'h7f80_0000});
    send_vector(FMT_B32, {32'hffc0_0001, 32'h7f80_0001, 32'h8000_0001, 32'h007f_ffff});
    send_vector(FMT_B32, {32'hbf00_0000, 32'h3f00_0000, 32'hbeff_ffff, 32'h3f7f_ffff});
    send_vector(FMT_B32, {32'hc020_0000, 32'h3fc0_0000, 32'h4b00_0000, 32'h4aff_ffff});
    send_vector(FMT_B32, {32'h7f7f_ffff, 32'hcb7f_ffff, 32'h3f80_0001, 32'hbfbf_ffff});
    send_vector(FMT_B32, {128{1'b1}});
    send_vector(FMT_B32, '0);
    send_vector(FMT_B64, {64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000});
    send_vector(FMT_B64, {64'hfff0_0000_0000_0000, 64'h7ff0_0000_0000_0000});
    send_vector(FMT_B64, {64'hfff8_0000_0000_0001, 64'h7ff0_0000_0000_0001});
    send_vector(FMT_B64, {64'hbfe0_0000_0000_0000, 64'h3fe0_0000_0000_0000});
    send_vector(FMT_B64, {64'hbfdf_ffff_ffff_ffff, 64'h0000_0000_0000_0001});
    send_vector(FMT_B64, {64'hc004_0000_0000_0000, 64'h3ff8_0000_0000_0000});
    send_vector(FMT_B64, {64'h4330_0000_0000_0000, 64'h432f_ffff_ffff_ffff});
    send_vector(FMT_B64, {64'h7fef_ffff_ffff_ffff, 64'h43e0_0000_0000_0001});
    send_vector(FMT_B64, {128{1'b1}});
    pause_sender(3);

    // Random part: bursts of mixed formats with random gaps between them.
    while (vectors_sent < 2000) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        fmt = fmt_t'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
          v = {$urandom(), $urandom(), $urandom(), $urandom()};
        else if (fmt == FMT_B64)
          v = {pick_double(), pick_double()};
        else
          v = {pick_single(), pick_single(), pick_single(), pick_single()};
        send_vector(fmt, v);
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (board.pending_rounded.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d vectors (%0d in binary64 lanes), checked %0d results.",
             vectors_sent, wide_sent, vectors_checked);
    if (mismatch_count == 0 && board.pending_rounded.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatch_count,
               board.pending_rounded.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Timeout waiting for results.");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
